### rtl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg: shared types and codes for the one-wire bus master
// Phase codes, command codes, register indexes and the timing set.
// ----------------------------------------------------------------------------
package owb_pkg;

   localparam int unsigned LONG_W  = 12;
   localparam int unsigned SHORT_W = 8;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [LONG_W-1:0]    long_ticks_type;
   typedef logic [SHORT_W-1:0]   short_ticks_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [2:0]           phase_type;
   typedef logic [1:0]           action_type;

   localparam phase_type PH_IDLE     = 3'd0;
   localparam phase_type PH_RST_LOW  = 3'd1;
   localparam phase_type PH_RST_WAIT = 3'd2;
   localparam phase_type PH_RST_REC  = 3'd3;
   localparam phase_type PH_WR_LOW   = 3'd4;
   localparam phase_type PH_WR_HIGH  = 3'd5;
   localparam phase_type PH_RD_LOW   = 3'd6;
   localparam phase_type PH_RD_HIGH  = 3'd7;

   localparam action_type ACT_TICK  = 2'd0;
   localparam action_type ACT_RESET = 2'd1;
   localparam action_type ACT_WRITE = 2'd2;
   localparam action_type ACT_READ  = 2'd3;

   localparam csr_index_type CSR_RESET_LOW     = 3'd0;
   localparam csr_index_type CSR_PRESENCE_WAIT = 3'd1;
   localparam csr_index_type CSR_RESET_REC     = 3'd2;
   localparam csr_index_type CSR_SLOT          = 3'd3;
   localparam csr_index_type CSR_WRITE_ONE_LOW = 3'd4;
   localparam csr_index_type CSR_READ_LOW      = 3'd5;
   localparam csr_index_type CSR_RECOVERY      = 3'd6;

   typedef struct packed {
      long_ticks_type  reset_low_ticks;
      long_ticks_type  presence_wait_ticks;
      long_ticks_type  reset_recovery_ticks;
      long_ticks_type  slot_ticks;
      short_ticks_type write_one_low_ticks;
      short_ticks_type read_low_ticks;
      short_ticks_type recovery_ticks;
   } cfg_type;

endpackage

### rtl/owb_intf.sv
// ----------------------------------------------------------------------------
// owb_intf: channel interfaces of the one-wire bus master
// Tick request channel, per-tick response channel and register write channel.
// ----------------------------------------------------------------------------
interface owb_req_if;
   logic                valid;
   logic                ready;
   owb_pkg::action_type action;
   logic [7:0]          write_byte;
   logic                bus_level;

   modport source (output valid, action, write_byte, bus_level, input ready);
   modport sink   (input valid, action, write_byte, bus_level, output ready);
endinterface

interface owb_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       device_present;
   logic [7:0] read_data;

   modport source (output valid, drive_low, busy_res, done_res, device_present, read_data,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, device_present, read_data,
                   output ready);
endinterface

interface owb_csr_if;
   logic                   valid;
   logic                   ready;
   owb_pkg::csr_index_type index;
   owb_pkg::long_ticks_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/owb_csr.sv
// ----------------------------------------------------------------------------
// owb_csr: timing register file
// Holds the seven bus timing values; takes one write beat per cycle.
// ----------------------------------------------------------------------------
module owb_csr (
   input  logic              clock,
   input  logic              reset,
   owb_csr_if.sink           csr_ch,
   output owb_pkg::cfg_type  cfg
);

   owb_pkg::cfg_type cfg_ff;
   owb_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            owb_pkg::CSR_RESET_LOW:     cfg_in.reset_low_ticks      = csr_ch.data;
            owb_pkg::CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks  = csr_ch.data;
            owb_pkg::CSR_RESET_REC:     cfg_in.reset_recovery_ticks = csr_ch.data;
            owb_pkg::CSR_SLOT:          cfg_in.slot_ticks           = csr_ch.data;
            owb_pkg::CSR_WRITE_ONE_LOW: cfg_in.write_one_low_ticks  = csr_ch.data[7:0];
            owb_pkg::CSR_READ_LOW:      cfg_in.read_low_ticks       = csr_ch.data[7:0];
            owb_pkg::CSR_RECOVERY:      cfg_in.recovery_ticks       = csr_ch.data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks      <= 12'd480;
         cfg_ff.presence_wait_ticks  <= 12'd60;
         cfg_ff.reset_recovery_ticks <= 12'd480;
         cfg_ff.slot_ticks           <= 12'd60;
         cfg_ff.write_one_low_ticks  <= 8'd1;
         cfg_ff.read_low_ticks       <= 8'd2;
         cfg_ff.recovery_ticks       <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/owb_engine.sv
// ----------------------------------------------------------------------------
// owb_engine: per-tick bus sequencer
// Input register, phase machine with tick and bit counters, response register.
// ----------------------------------------------------------------------------
module owb_engine (
   input  logic              clock,
   input  logic              reset,
   input  owb_pkg::cfg_type  cfg,
   owb_req_if.sink           req_ch,
   owb_rsp_if.source         rsp_ch
);

   // input register
   logic                in_valid_ff;
   owb_pkg::action_type in_action_ff;
   logic [7:0]          in_byte_ff;
   logic                in_level_ff;

   // sequencer state
   owb_pkg::phase_type      phase_ff, phase_in;
   owb_pkg::long_ticks_type tick_ff, tick_in;
   logic [2:0]              bit_ff, bit_in;
   logic [7:0]              shift_ff, shift_in;
   owb_pkg::action_type     kind_ff, kind_in;
   logic                    presence_ff, presence_in;
   logic [7:0]              held_ff, held_in;

   // response register
   logic       rsp_valid_ff;
   logic       drive_ff, drive_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;

   logic step_en;
   logic take_req;

   assign step_en  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step_en;
   assign take_req = req_ch.valid && req_ch.ready;

   always_comb begin
      owb_pkg::long_ticks_type len;
      logic                    bit_val;
      logic                    over;
      logic                    last_bit;

      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      kind_in     = kind_ff;
      presence_in = presence_ff;
      held_in     = held_ff;
      drive_in    = 1'b0;
      done_in     = 1'b0;

      if (phase_ff == owb_pkg::PH_IDLE && in_action_ff != owb_pkg::ACT_TICK) begin
         kind_in = in_action_ff;
         tick_in = '0;
         bit_in  = '0;
         unique case (in_action_ff)
            owb_pkg::ACT_RESET: phase_in = owb_pkg::PH_RST_LOW;
            owb_pkg::ACT_WRITE: begin
               shift_in = in_byte_ff;
               phase_in = owb_pkg::PH_WR_LOW;
            end
            default: begin
               shift_in = '0;
               phase_in = owb_pkg::PH_RD_LOW;
            end
         endcase
      end

      busy_in = (phase_in != owb_pkg::PH_IDLE);
      bit_val = shift_in[bit_in];

      // length of the current phase
      case (phase_in)
         owb_pkg::PH_RST_LOW:  len = cfg.reset_low_ticks;
         owb_pkg::PH_RST_WAIT: len = cfg.presence_wait_ticks;
         owb_pkg::PH_RST_REC:  len = cfg.reset_recovery_ticks;
         owb_pkg::PH_WR_LOW:   len = bit_val ? {4'd0, cfg.write_one_low_ticks} : cfg.slot_ticks;
         owb_pkg::PH_WR_HIGH:  len = bit_val ? cfg.slot_ticks : {4'd0, cfg.recovery_ticks};
         owb_pkg::PH_RD_LOW:   len = {4'd0, cfg.read_low_ticks};
         owb_pkg::PH_RD_HIGH:  len = cfg.slot_ticks;
         default:              len = '0;
      endcase

      over     = ({1'b0, tick_in} + 13'd1) >= {1'b0, len};
      last_bit = (bit_in == 3'd7);

      // samples use the tick count before it advances
      if (phase_in == owb_pkg::PH_RST_REC && tick_in == '0) begin
         presence_in = ~in_level_ff;
      end
      if (phase_in == owb_pkg::PH_RD_HIGH && tick_in == '0 && in_level_ff) begin
         shift_in[bit_in] = 1'b1;
      end

      if (phase_in != owb_pkg::PH_IDLE) begin
         tick_in = over ? '0 : tick_in + 12'd1;
      end

      unique case (phase_in)
         owb_pkg::PH_RST_LOW: begin
            drive_in = 1'b1;
            if (over) phase_in = owb_pkg::PH_RST_WAIT;
         end
         owb_pkg::PH_RST_WAIT: begin
            if (over) phase_in = owb_pkg::PH_RST_REC;
         end
         owb_pkg::PH_RST_REC: begin
            if (over) begin
               phase_in = owb_pkg::PH_IDLE;
               done_in  = 1'b1;
            end
         end
         owb_pkg::PH_WR_LOW: begin
            drive_in = 1'b1;
            if (over) phase_in = owb_pkg::PH_WR_HIGH;
         end
         owb_pkg::PH_RD_LOW: begin
            drive_in = 1'b1;
            if (over) phase_in = owb_pkg::PH_RD_HIGH;
         end
         owb_pkg::PH_WR_HIGH, owb_pkg::PH_RD_HIGH: begin
            if (over) begin
               if (last_bit) begin
                  if (kind_in == owb_pkg::ACT_READ) held_in = shift_in;
                  phase_in = owb_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  bit_in   = bit_in + 3'd1;
                  phase_in = (kind_in == owb_pkg::ACT_WRITE) ? owb_pkg::PH_WR_LOW
                                                             : owb_pkg::PH_RD_LOW;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= owb_pkg::PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         kind_ff      <= owb_pkg::ACT_TICK;
         presence_ff  <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         if (step_en) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            kind_ff      <= kind_in;
            presence_ff  <= presence_in;
            held_ff      <= held_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff <= req_ch.action;
         in_byte_ff   <= req_ch.write_byte;
         in_level_ff  <= req_ch.bus_level;
      end
      if (step_en) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive_low      = drive_ff;
   assign rsp_ch.busy_res       = busy_ff;
   assign rsp_ch.done_res       = done_ff;
   assign rsp_ch.device_present = presence_ff;
   assign rsp_ch.read_data      = held_ff;

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff |-> busy_ff)
      else $error("line driven outside a command");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done_in |=> phase_ff == owb_pkg::PH_IDLE)
      else $error("sequencer not idle after done");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      !(step_en && done_in) |=> $stable(held_ff))
      else $error("read byte changed without a finished command");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_valid_ff && !rsp_ch.ready)
      else $error("request blocked without response back-pressure");

endmodule

### rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: timed master for a single-wire open-drain bus
// Top level: timing register file and per-tick sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one beat per bus tick (normally 1 us): an action code
//   (tick only, bus reset, write byte, read byte), the byte to send and the
//   sampled line level. Actions are taken only while no command is running.
//   rsp_ch returns exactly one beat per request beat: drive_low for the
//   open-drain driver, busy/done flags, the presence result of the last bus
//   reset and the byte of the last finished read.
//   csr_ch writes the seven timing registers by index; write only while idle.
// Pipeline:
//   A request beat is captured in the input register, then its response
//   is registered: one beat per cycle sustained while rsp_ch is ready, limited
//   by the single phase/counter update between the two registers.
// Reset: all timing registers return to their defaults, the sequencer goes
//   idle, presence and read byte clear.
// Stall: while rsp_ch is not ready the held response stays put, one more
//   request beat is buffered, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
   input  logic        clock,
   input  logic        reset,
   owb_req_if.sink     req_ch,
   owb_rsp_if.source   rsp_ch,
   owb_csr_if.sink     csr_ch
);

   owb_pkg::cfg_type cfg;

   owb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   owb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

### tb/one_wire_bus_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb: self-checking bench for the one-wire bus master
// Streams bus ticks through the request channel and predicts the line drive,
// busy/done flags, presence result and read byte of every response beat. A
// directed script runs first under the all-ones timing set. Random reset,
// write and read commands with random line levels follow under it, then under
// small sets with random gaps on both channels and the zero set with none.
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam owb_pkg::csr_index_type CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic       present;
      logic [7:0] read_data;
   } line_status_type;

   typedef struct packed {
      owb_pkg::long_ticks_type reset_low;
      owb_pkg::long_ticks_type presence_wait;
      owb_pkg::long_ticks_type reset_rec;
      owb_pkg::long_ticks_type slot;
      owb_pkg::long_ticks_type write_one_low;
      owb_pkg::long_ticks_type read_low;
      owb_pkg::long_ticks_type recovery;
   } timing_set_type;

   typedef struct packed {
      owb_pkg::action_type action;
      logic [7:0]          wbyte;
      logic                level;
      logic [4:0]          reps;
      logic                typed;
      line_status_type     status;
   } script_row_type;

   localparam script_row_type DIRECTED_ROWS [19] = '{
      '{owb_pkg::ACT_TICK,  8'h00, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_TICK,  8'hFF, 1'b0, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_RESET, 8'h00, 1'b0, 5'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b0, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b0, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00}},
      '{owb_pkg::ACT_RESET, 8'h00, 1'b1, 5'd3,  1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_WRITE, 8'hFF, 1'b1, 5'd1,  1'b0, '0},
      '{owb_pkg::ACT_READ,  8'h00, 1'b0, 5'd14, 1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{owb_pkg::ACT_WRITE, 8'h00, 1'b0, 5'd16, 1'b0, '0},
      '{owb_pkg::ACT_WRITE, 8'hA5, 1'b1, 5'd16, 1'b0, '0},
      '{owb_pkg::ACT_READ,  8'h00, 1'b1, 5'd1,  1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b1, 5'd14, 1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'h00, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'hFF}},
      '{owb_pkg::ACT_READ,  8'hFF, 1'b0, 5'd16, 1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'h55, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{owb_pkg::ACT_RESET, 8'hFF, 1'b0, 5'd3,  1'b0, '0},
      '{owb_pkg::ACT_TICK,  8'hAA, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}}
   };

   localparam timing_set_type MIN_SET  = '{12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1};
   localparam timing_set_type ZERO_SET = '{12'd0, 12'd0, 12'd0, 12'd0,
                                           12'hF00, 12'hF00, 12'hF00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   owb_req_if req_ch ();
   owb_rsp_if rsp_ch ();
   owb_csr_if csr_ch ();

   one_wire_bus_master u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   owb_pkg::cfg_type        timing;
   owb_pkg::phase_type      bm_phase;
   owb_pkg::long_ticks_type bm_ticks;
   logic [2:0]              bm_bit;
   logic [7:0]              bm_shift;
   owb_pkg::action_type     bm_kind;
   logic                    bm_present;
   logic [7:0]              bm_read;

   line_status_type expected_line_states [$];
   int  mismatches   = 0;
   int  ticks_sent   = 0;
   int  n_resets     = 0;
   int  n_writes     = 0;
   int  n_reads      = 0;
   int  timing_sets  = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  steady_flow  = 1'b0;

   function automatic bit span_done(owb_pkg::long_ticks_type len);
      if (({1'b0, bm_ticks} + 13'd1) >= {1'b0, len}) begin
         bm_ticks = '0;
         return 1'b1;
      end
      bm_ticks = bm_ticks + 12'd1;
      return 1'b0;
   endfunction

   function automatic bit next_slot();
      if (bm_bit == 3'd7) begin
         if (bm_kind == owb_pkg::ACT_READ) bm_read = bm_shift;
         bm_phase = owb_pkg::PH_IDLE;
         return 1'b1;
      end
      bm_bit   = bm_bit + 3'd1;
      bm_phase = (bm_kind == owb_pkg::ACT_WRITE) ? owb_pkg::PH_WR_LOW : owb_pkg::PH_RD_LOW;
      return 1'b0;
   endfunction

   function automatic void apply_timing_write(owb_pkg::csr_index_type idx,
                                              owb_pkg::long_ticks_type data);
      case (idx)
         owb_pkg::CSR_RESET_LOW:     timing.reset_low_ticks      = data;
         owb_pkg::CSR_PRESENCE_WAIT: timing.presence_wait_ticks  = data;
         owb_pkg::CSR_RESET_REC:     timing.reset_recovery_ticks = data;
         owb_pkg::CSR_SLOT:          timing.slot_ticks           = data;
         owb_pkg::CSR_WRITE_ONE_LOW: timing.write_one_low_ticks  = data[7:0];
         owb_pkg::CSR_READ_LOW:      timing.read_low_ticks       = data[7:0];
         owb_pkg::CSR_RECOVERY:      timing.recovery_ticks       = data[7:0];
         default: ;
      endcase
   endfunction

   function automatic line_status_type predict_bus_tick(owb_pkg::action_type act,
                                                        logic [7:0] wbyte, logic level);
      line_status_type         st;
      logic                    bit_val;
      owb_pkg::long_ticks_type one_low;
      owb_pkg::long_ticks_type rd_low;
      owb_pkg::long_ticks_type rec_len;
      st      = '0;
      one_low = {4'd0, timing.write_one_low_ticks};
      rd_low  = {4'd0, timing.read_low_ticks};
      rec_len = {4'd0, timing.recovery_ticks};
      if (bm_phase == owb_pkg::PH_IDLE && act != owb_pkg::ACT_TICK) begin
         bm_kind  = act;
         bm_ticks = '0;
         bm_bit   = '0;
         case (act)
            owb_pkg::ACT_RESET: begin
               bm_phase = owb_pkg::PH_RST_LOW;
               n_resets++;
            end
            owb_pkg::ACT_WRITE: begin
               bm_shift = wbyte;
               bm_phase = owb_pkg::PH_WR_LOW;
               n_writes++;
            end
            default: begin
               bm_shift = '0;
               bm_phase = owb_pkg::PH_RD_LOW;
               n_reads++;
            end
         endcase
      end
      st.busy = (bm_phase != owb_pkg::PH_IDLE);
      bit_val = bm_shift[bm_bit];
      case (bm_phase)
         owb_pkg::PH_RST_LOW: begin
            st.drive_low = 1'b1;
            if (span_done(timing.reset_low_ticks)) bm_phase = owb_pkg::PH_RST_WAIT;
         end
         owb_pkg::PH_RST_WAIT: begin
            if (span_done(timing.presence_wait_ticks)) bm_phase = owb_pkg::PH_RST_REC;
         end
         owb_pkg::PH_RST_REC: begin
            if (bm_ticks == '0) bm_present = !level;
            if (span_done(timing.reset_recovery_ticks)) begin
               bm_phase = owb_pkg::PH_IDLE;
               st.done  = 1'b1;
            end
         end
         owb_pkg::PH_WR_LOW: begin
            st.drive_low = 1'b1;
            if (span_done(bit_val ? one_low : timing.slot_ticks))
               bm_phase = owb_pkg::PH_WR_HIGH;
         end
         owb_pkg::PH_WR_HIGH: begin
            if (span_done(bit_val ? timing.slot_ticks : rec_len))
               st.done = next_slot();
         end
         owb_pkg::PH_RD_LOW: begin
            st.drive_low = 1'b1;
            if (span_done(rd_low)) bm_phase = owb_pkg::PH_RD_HIGH;
         end
         owb_pkg::PH_RD_HIGH: begin
            if (bm_ticks == '0 && level) bm_shift[bm_bit] = 1'b1;
            if (span_done(timing.slot_ticks)) st.done = next_slot();
         end
         default: ;
      endcase
      st.present   = bm_present;
      st.read_data = bm_read;
      return st;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_bus_tick(owb_pkg::action_type act, logic [7:0] wbyte, logic level,
                                logic typed, line_status_type typed_status);
      line_status_type st;
      int              gap;
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.write_byte <= wbyte;
      req_ch.bus_level  <= level;
      do @(posedge clock); while (!req_ch.ready);
      st = predict_bus_tick(act, wbyte, level);
      expected_line_states.push_back(typed ? typed_status : st);
      ticks_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (expected_line_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(owb_pkg::csr_index_type idx, owb_pkg::long_ticks_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      apply_timing_write(idx, data);
   endtask

   task automatic load_timing(timing_set_type ts, bit poke_unused);
      csr_put(owb_pkg::CSR_RESET_LOW,     ts.reset_low);
      csr_put(owb_pkg::CSR_PRESENCE_WAIT, ts.presence_wait);
      csr_put(owb_pkg::CSR_RESET_REC,     ts.reset_rec);
      csr_put(owb_pkg::CSR_SLOT,          ts.slot);
      csr_put(owb_pkg::CSR_WRITE_ONE_LOW, ts.write_one_low);
      csr_put(owb_pkg::CSR_READ_LOW,      ts.read_low);
      csr_put(owb_pkg::CSR_RECOVERY,      ts.recovery);
      if (poke_unused)
         csr_put(CSR_UNUSED, owb_pkg::long_ticks_type'($urandom_range(0, 4095)));
      csr_ch.valid <= 1'b0;
      timing_sets++;
   endtask

   function automatic timing_set_type small_timing();
      timing_set_type ts;
      ts.reset_low     = owb_pkg::long_ticks_type'($urandom_range(1, 6));
      ts.presence_wait = owb_pkg::long_ticks_type'($urandom_range(1, 6));
      ts.reset_rec     = owb_pkg::long_ticks_type'($urandom_range(1, 6));
      ts.slot          = owb_pkg::long_ticks_type'($urandom_range(1, 6));
      ts.write_one_low = {4'($urandom_range(0, 15)), 8'($urandom_range(1, 6))};
      ts.read_low      = {4'($urandom_range(0, 15)), 8'($urandom_range(1, 6))};
      ts.recovery      = {4'($urandom_range(0, 15)), 8'($urandom_range(1, 6))};
      return ts;
   endfunction

   task automatic run_commands(int count, bit keep_flowing);
      owb_pkg::action_type act;
      for (int c = 0; c < count; c++) begin
         steady_flow = keep_flowing || ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0) quiesce();
         repeat ($urandom_range(0, 2))
            send_bus_tick(owb_pkg::ACT_TICK, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
         act = owb_pkg::action_type'($urandom_range(1, 3));
         send_bus_tick(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
         while (bm_phase != owb_pkg::PH_IDLE)
            send_bus_tick(owb_pkg::action_type'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      steady_flow = 1'b0;
   endtask

   task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   task automatic check_bus_beat();
      line_status_type got;
      line_status_type want;
      got = '{rsp_ch.drive_low, rsp_ch.busy_res, rsp_ch.done_res, rsp_ch.device_present,
              rsp_ch.read_data};
      if (expected_line_states.size() == 0) begin
         $display("%0t: unexpected response beat %h", $time, got);
         mismatches++;
      end else begin
         want = expected_line_states.pop_front();
         compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
         compare_field("busy_res", 8'(want.busy), 8'(got.busy));
         compare_field("done_res", 8'(want.done), 8'(got.done));
         compare_field("device_present", 8'(want.present), 8'(got.present));
         compare_field("read_data", want.read_data, got.read_data);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_bus_beat();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.action     = owb_pkg::ACT_TICK;
      req_ch.write_byte = '0;
      req_ch.bus_level  = 1'b1;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = owb_pkg::CSR_RESET_LOW;
      csr_ch.data       = '0;
      rsp_ch.ready      = 1'b0;

      timing.reset_low_ticks      = 12'd480;
      timing.presence_wait_ticks  = 12'd60;
      timing.reset_recovery_ticks = 12'd480;
      timing.slot_ticks           = 12'd60;
      timing.write_one_low_ticks  = 8'd1;
      timing.read_low_ticks       = 8'd2;
      timing.recovery_ticks       = 8'd1;
      bm_phase   = owb_pkg::PH_IDLE;
      bm_ticks   = '0;
      bm_bit     = '0;
      bm_shift   = '0;
      bm_kind    = owb_pkg::ACT_TICK;
      bm_present = 1'b0;
      bm_read    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_timing(MIN_SET, 1'b0);
      foreach (DIRECTED_ROWS[r])
         repeat (DIRECTED_ROWS[r].reps)
            send_bus_tick(DIRECTED_ROWS[r].action, DIRECTED_ROWS[r].wbyte,
                          DIRECTED_ROWS[r].level, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].status);
      run_commands(8, 1'b0);

      repeat (3) begin
         quiesce();
         load_timing(small_timing(), 1'b1);
         run_commands(2, 1'b0);
      end

      quiesce();
      load_timing(ZERO_SET, 1'b1);
      run_commands(4, 1'b1);

      quiesce();
      $display("covered %0d bus ticks: %0d resets, %0d writes, %0d reads",
               ticks_sent, n_resets, n_writes, n_reads);
      $display("across %0d timing sets, %0d mismatches", timing_sets, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
rtl/owb_pkg.sv
rtl/owb_intf.sv
rtl/owb_csr.sv
rtl/owb_engine.sv
rtl/one_wire_bus_master.sv
tb/one_wire_bus_master_tb.sv
